### src/rse_pkg.sv
// shared types, field constants and the gf(2^8) multiply for the rs parity encoder
// no dependencies; used by every module under src
package rse_pkg;

    // field polynomial x^8+x^4+x^3+x^2+1 and primitive element
    localparam logic [8:0] FIELD_POLY   = 9'h11D;
    localparam logic [7:0] FIELD_ALPHA  = 8'h02;
    localparam int         RESET_DEGREE = 10;
    localparam int         CFG_WIDTH    = 5;

    // queue status towards producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // gf(2^8) multiply, msb-first shift and reduce
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int bit_idx = 7; bit_idx >= 0; bit_idx--) begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? FIELD_POLY[7:0] : 8'h00);
            acc = acc ^ (b[bit_idx] ? a : 8'h00);
        end
        return acc;
    endfunction

endpackage

### src/rse_gen.sv
// generator polynomial builder and degree register for the rs parity encoder
// depends on rse_pkg
module rse_gen #(
    parameter int MAX_DEGREE = 30,
    parameter int DW         = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rse_pkg::CFG_WIDTH-1:0] i_degree,
    output logic [MAX_DEGREE-1:0][7:0]  o_coeffs,
    output logic [DW-1:0]               o_degree,
    output logic                        o_busy
);

    localparam int RST_DEG = (rse_pkg::RESET_DEGREE > MAX_DEGREE) ? MAX_DEGREE
                                                                  : rse_pkg::RESET_DEGREE;

    logic [MAX_DEGREE-1:0][7:0] r_g;
    logic [MAX_DEGREE-1:0][7:0] n_g;
    logic [MAX_DEGREE-1:0][7:0] w_seed;
    logic [7:0]                 r_root;
    logic [DW-1:0]              r_cnt;
    logic [DW-1:0]              r_deg;
    logic [DW-1:0]              w_deg_clamped;
    logic [DW-1:0]              w_seed_deg;

    // saturate the written degree to 1..MAX_DEGREE
    always_comb begin
        if (i_degree == '0) begin
            w_deg_clamped = DW'(1);
        end else if (int'(i_degree) > MAX_DEGREE) begin
            w_deg_clamped = DW'(MAX_DEGREE);
        end else begin
            w_deg_clamped = DW'(i_degree);
        end
    end

    // seed polynomial: a single one at position degree-1
    assign w_seed_deg = i_rst_n ? w_deg_clamped : DW'(RST_DEG);
    always_comb begin
        for (int j = 0; j < MAX_DEGREE; j++) begin
            w_seed[j] = (DW'(j) == w_seed_deg - DW'(1)) ? 8'h01 : 8'h00;
        end
    end

    // one round: multiply by (x - root), all taps at once
    always_comb begin
        for (int j = 0; j < MAX_DEGREE - 1; j++) begin
            n_g[j] = rse_pkg::gf_mul(r_g[j], r_root) ^ r_g[j+1];
        end
        n_g[MAX_DEGREE-1] = rse_pkg::gf_mul(r_g[MAX_DEGREE-1], r_root);
    end

    // round counter, root and coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= DW'(RST_DEG);
            r_deg  <= DW'(RST_DEG);
            r_root <= 8'h01;
            r_g    <= w_seed;
        end else if (i_start) begin
            r_cnt  <= w_deg_clamped;
            r_deg  <= w_deg_clamped;
            r_root <= 8'h01;
            r_g    <= w_seed;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - DW'(1);
            r_root <= rse_pkg::gf_mul(r_root, rse_pkg::FIELD_ALPHA);
            r_g    <= n_g;
        end
    end

    assign o_coeffs = r_g;
    assign o_degree = r_deg;
    assign o_busy   = (r_cnt != '0);

endmodule

### src/rse_front.sv
// front end: request intake and remainder lfsr of the rs parity encoder
// depends on rse_pkg; feeds rse_queue with one remainder snapshot per block
module rse_front #(
    parameter int MAX_DEGREE = 30,
    parameter int DW         = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_block_end,
    input  logic                       i_clear,
    input  logic                       i_gen_busy,
    input  logic [MAX_DEGREE-1:0][7:0] i_coeffs,
    input  logic [DW-1:0]              i_degree,
    input  rse_pkg::t_q_stat           i_q_stat,
    output logic                       o_full,
    output logic                       o_q_push,
    output logic [MAX_DEGREE*8+DW-1:0] o_q_data
);

    logic [MAX_DEGREE-1:0][7:0] r_rem;
    logic [MAX_DEGREE-1:0][7:0] n_rem;
    logic [7:0]                 w_factor;
    logic                       w_accept;

    // hold off while the generator is rebuilt or the queue has no room
    assign o_full   = i_gen_busy || i_q_stat.full;
    assign w_accept = i_push && !o_full;

    // shift and fold in one byte; taps above the degree stay zero
    assign w_factor = i_data_byte ^ r_rem[0];
    always_comb begin
        for (int j = 0; j < MAX_DEGREE - 1; j++) begin
            n_rem[j] = r_rem[j+1] ^ rse_pkg::gf_mul(i_coeffs[j], w_factor);
        end
        n_rem[MAX_DEGREE-1] = rse_pkg::gf_mul(i_coeffs[MAX_DEGREE-1], w_factor);
    end

    // remainder register, cleared at block end and on degree change
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_rem <= '0;
        end else if (w_accept) begin
            if (i_block_end) begin
                r_rem <= '0;
            end else begin
                r_rem <= n_rem;
            end
        end
    end

    assign o_q_push = w_accept && i_block_end;
    assign o_q_data = {i_degree, n_rem};

endmodule

### src/rse_queue.sv
// small block queue between front end and parity serialiser
// depends on rse_pkg for the status struct
module rse_queue #(
    parameter int W     = 248,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [W-1:0]     i_data,
    input  logic             i_pop,
    output logic [W-1:0]     o_data,
    output rse_pkg::t_q_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_data       = r_mem[r_rptr];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

### src/rse_back.sv
// back end: serialises one remainder snapshot into parity bytes
// depends on rse_pkg; drains rse_queue
module rse_back #(
    parameter int MAX_DEGREE = 30,
    parameter int DW         = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [MAX_DEGREE*8+DW-1:0] i_q_data,
    input  rse_pkg::t_q_stat           i_q_stat,
    output logic                       o_q_pop,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [7:0]                 o_parity_byte,
    output logic                       o_parity_last
);

    logic [MAX_DEGREE-1:0][7:0] r_par;
    logic [DW-1:0]              r_cnt;
    logic                       w_take;
    logic                       w_load;

    assign o_empty = (r_cnt == '0);
    assign w_take  = i_pop && !o_empty;

    // refill from the queue when idle or as the final byte leaves
    assign w_load  = !i_q_stat.empty && (o_empty || (w_take && r_cnt == DW'(1)));
    assign o_q_pop = w_load;

    // parity byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_load) begin
            r_cnt <= i_q_data[MAX_DEGREE*8 +: DW];
        end else if (w_take) begin
            r_cnt <= r_cnt - DW'(1);
        end
    end

    // parity shift register, head at index 0
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_par <= i_q_data[MAX_DEGREE*8-1:0];
        end else if (w_take) begin
            r_par <= {8'h00, r_par[MAX_DEGREE-1:1]};
        end
    end

    assign o_parity_byte = r_par[0];
    assign o_parity_last = (r_cnt == DW'(1));

endmodule

### src/reed_solomon_ecc_encoder.sv
// top level of the systematic reed-solomon parity encoder over gf(2^8), poly 0x11d
// depends on rse_pkg, rse_gen, rse_front, rse_queue, rse_back

// Data bytes are taken one per clock while full is low; each byte is folded
// into a remainder register whose taps all update in the same cycle. The
// byte flagged block_end hands its remainder to a two-block queue and the
// next block can start on the following cycle. Parity bytes leave one per
// pop, highest order first, with parity_last on the final one; the
// serialiser plus queue buffer up to three finished blocks, so full rises
// at a block end only if the result side has fallen that far behind. After
// reset and after every degree write the generator is rebuilt, one root per
// cycle, and full stays high until the rebuild is done (the reset degree is
// 10). A degree write also drops any partial block. Written degrees
// saturate to the range 1..MAX_DEGREE.
module reed_solomon_ecc_encoder #(
    parameter int MAX_DEGREE = 30
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_block_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_parity_byte,
    output logic       o_parity_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [rse_pkg::CFG_WIDTH-1:0] i_ecc_degree
);

    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int QW = MAX_DEGREE * 8 + DW;

    logic [MAX_DEGREE-1:0][7:0] w_coeffs;
    logic [DW-1:0]              w_degree;
    logic                       w_gen_busy;
    logic                       w_cfg_wr;
    logic                       w_q_push;
    logic                       w_q_pop;
    logic [QW-1:0]              w_q_wdata;
    logic [QW-1:0]              w_q_rdata;
    rse_pkg::t_q_stat           w_q_stat;

    // configuration channel always ready
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    rse_gen #(
        .MAX_DEGREE (MAX_DEGREE),
        .DW         (DW)
    ) u_gen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_cfg_wr),
        .i_degree (i_ecc_degree),
        .o_coeffs (w_coeffs),
        .o_degree (w_degree),
        .o_busy   (w_gen_busy)
    );

    rse_front #(
        .MAX_DEGREE (MAX_DEGREE),
        .DW         (DW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_block_end (i_block_end),
        .i_clear     (w_cfg_wr),
        .i_gen_busy  (w_gen_busy),
        .i_coeffs    (w_coeffs),
        .i_degree    (w_degree),
        .i_q_stat    (w_q_stat),
        .o_full      (full),
        .o_q_push    (w_q_push),
        .o_q_data    (w_q_wdata)
    );

    rse_queue #(
        .W     (QW),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_stat  (w_q_stat)
    );

    rse_back #(
        .MAX_DEGREE (MAX_DEGREE),
        .DW         (DW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_data      (w_q_rdata),
        .i_q_stat      (w_q_stat),
        .o_q_pop       (w_q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_parity_byte (o_parity_byte),
        .o_parity_last (o_parity_last)
    );

    // no request taken while the generator is being rebuilt
    a_no_push_during_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_gen_busy |-> full)
        else $error("request accepted during generator rebuild");

    // a finished block never meets a full queue
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_stat.full)
        else $error("block queue overflow");

    // a non-final parity byte is always followed by another one
    a_block_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_parity_last) |=> !empty)
        else $error("parity block cut short");

    // final byte with nothing queued leaves the output side empty
    a_block_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_parity_last && w_q_stat.empty) |=> empty)
        else $error("parity byte appeared without a block");

endmodule
